// ----- src/variable_density_track_detector_unit_defines.svh -----
// Assertion macros shared by the track detector RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef VARIABLE_DENSITY_TRACK_DETECTOR_UNIT_DEFINES_SVH
`define VARIABLE_DENSITY_TRACK_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define VDTD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define VDTD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/vdtd_pkg.sv -----
// Types, widths and constants for the variable density track detector.
// No dependencies; imported by variable_density_track_detector_unit, track_status_checker and the testbench.
`timescale 1ns / 1ps

package vdtd_pkg;

    // Calibration length and offset width.
    localparam int CAL_GROUPS = 2000;
    localparam int OFS_W      = 18;

    // Fixed field widths of the stream words.
    localparam int LAT_W      = 24;
    localparam int BOF_W      = 18;
    localparam int DBO_W      = 18;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = ((LAT_W + BOF_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((DBO_W + 7) / 8) * 8;

    // Calibration arithmetic: running quotient and remainder of the sum by CAL_GROUPS.
    localparam int CNT_W    = $clog2(CAL_GROUPS + 1);
    localparam int REM_W    = $clog2(CAL_GROUPS);
    localparam int RECIP_SH = LAT_W + $clog2(CAL_GROUPS);
    localparam int RECIP_W  = LAT_W + 1;
    localparam longint unsigned RECIP =
        ((longint'(1) << RECIP_SH) + longint'(CAL_GROUPS) - 1) / longint'(CAL_GROUPS);
    localparam int RPROD_W  = LAT_W + RECIP_W;
    localparam int QSEL_W   = RPROD_W - RECIP_SH;

    // Threshold comparison: latency scaled by the percentage base against avg * percent.
    localparam int PROD_W     = LAT_W + 8;
    localparam int PCT_BASE   = 100;
    localparam int LONG_PCT   = 108;
    localparam int SHORT_PCT  = 92;
    localparam int NORMAL_PCT = 98;

    // Offset checks and data offset rounding.
    localparam int WIN_LO     = 75000;
    localparam int WIN_HI     = 80000;
    localparam int LEN_MIN    = 500;
    localparam int LEN_MAX    = 800;
    localparam int RND_HALF   = 64;
    localparam int RND_MASK   = 127;
    localparam int DATA_BACK  = 640;

    typedef logic [OFS_W-1:0] t_ofs;

    typedef enum logic [2:0] {
        PH_CALIB  = 3'd0,
        PH_LONG   = 3'd1,
        PH_SHORT  = 3'd2,
        PH_NORMAL = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND  = 3'd0,
        ST_STREAM = 3'd1,
        ST_ORDER  = 3'd2,
        ST_WINDOW = 3'd3,
        ST_LENGTH = 3'd4
    } t_status;

endpackage

// ----- src/variable_density_track_detector_unit.sv -----
// Variable density track detector: calibration, region search and offset checks.
// Depends on vdtd_pkg and variable_density_track_detector_unit_defines.svh.
//
//  Channel   Direction  Word contents
//  s_axis    in         tdata: group_latency[23:0], bit_offset[41:24]; tuser: track_start;
//                       tlast: stream_end
//  m_axis    out        tdata: data_bit_offset[17:0]; tuser: status
//
// One word is taken every cycle while no status word holds the pipeline; a word passes
// four register stages (input, reciprocal multiply, remainder, detection) and its status
// word is registered with the detection state once the output can take it. The reciprocal
// multiply by 1/CAL_GROUPS and the threshold multiply of the stored average each fill one
// stage. Reset is synchronous and active low and leaves the block calibrating; no clearing
// pass is needed. While a status word waits on the output, words that produce no status
// keep flowing; only a word that would produce one holds the pipeline.
`timescale 1ns / 1ps
`include "variable_density_track_detector_unit_defines.svh"

module variable_density_track_detector_unit
    import vdtd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // group_latency, bit_offset
    input  logic                  i_s_axis_tuser,   // track_start
    input  logic                  i_s_axis_tlast,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // data_bit_offset
    output logic [STATUS_W-1:0]   o_m_axis_tuser    // status
);

    // Pipeline stage registers.
    logic                r_v1, r_v2, r_v3;
    logic                r1_ts, r1_se, r2_ts, r2_se, r3_ts, r3_se;
    logic [LAT_W-1:0]    r1_lat, r2_lat;
    t_ofs                r1_ofs, r2_ofs, r3_ofs;
    logic [QSEL_W-1:0]   r2_quo, r3_quo;
    logic [PROD_W-1:0]   r2_lat100, r3_lat100;
    logic [REM_W-1:0]    r3_rem;

    // Detection state.
    t_phase              r_phase, n_phase;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [LAT_W-1:0]    r_q, n_q;
    logic [REM_W-1:0]    r_rem, n_rem;
    t_ofs                r_long, n_long, r_short, n_short;

    // Output register.
    logic                r_ov;
    t_status             r_out_status;
    logic [DBO_W-1:0]    r_out_data;

    // Flow control.
    logic                c_out_free, c_take3, c_free3, c_free2, c_free1;
    logic                c_emit;
    t_status             c_status;
    logic [DBO_W-1:0]    c_data;

    // Arithmetic helpers.
    logic [RPROD_W-1:0]  c_rprod;
    logic [LAT_W-1:0]    c_rem_full;
    t_phase              e_phase;
    logic [CNT_W-1:0]    e_cnt;
    logic [LAT_W-1:0]    e_q;
    logic [REM_W-1:0]    e_rem;
    logic [REM_W:0]      c_rsum;
    logic                c_carry;
    logic [PROD_W-1:0]   c_q_long, c_q_short, c_q_normal, c_lat_up;
    logic                c_hit_long, c_hit_short, c_hit_normal;
    t_ofs                c_diff, c_len, c_rnd, c_dofs;
    t_status             c_fin_status;

    // A word leaves the detection stage when it yields nothing or the output can take it.
    assign c_out_free      = !r_ov || i_m_axis_tready;
    assign c_take3         = r_v3 && (!c_emit || c_out_free);
    assign c_free3         = !r_v3 || c_take3;
    assign c_free2         = !r_v2 || c_free3;
    assign c_free1         = !r_v1 || c_free2;
    assign o_s_axis_tready = c_free1;

    // Stage one: input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (c_free1) begin
            r_v1 <= i_s_axis_tvalid;
        end
        if (c_free1 && i_s_axis_tvalid) begin
            r1_ts  <= i_s_axis_tuser;
            r1_se  <= i_s_axis_tlast;
            r1_lat <= i_s_axis_tdata[LAT_W-1:0];
            r1_ofs <= t_ofs'(i_s_axis_tdata[LAT_W +: BOF_W]);
        end
    end

    // Stage two: quotient of the latency by CAL_GROUPS and the scaled latency.
    assign c_rprod = RPROD_W'(r1_lat) * RPROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (c_free2) begin
            r_v2 <= r_v1;
        end
        if (c_free2 && r_v1) begin
            r2_ts     <= r1_ts;
            r2_se     <= r1_se;
            r2_lat    <= r1_lat;
            r2_ofs    <= r1_ofs;
            r2_quo    <= c_rprod[RECIP_SH +: QSEL_W];
            r2_lat100 <= PROD_W'(r1_lat) * PROD_W'(PCT_BASE);
        end
    end

    // Stage three: remainder of the latency by CAL_GROUPS.
    assign c_rem_full = r2_lat - LAT_W'(r2_quo) * LAT_W'(CAL_GROUPS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (c_free3) begin
            r_v3 <= r_v2;
        end
        if (c_free3 && r_v2) begin
            r3_ts     <= r2_ts;
            r3_se     <= r2_se;
            r3_ofs    <= r2_ofs;
            r3_quo    <= r2_quo;
            r3_lat100 <= r2_lat100;
            r3_rem    <= REM_W'(c_rem_full);
        end
    end

    // A track start clears the calibration state before this word is handled.
    assign e_phase = r3_ts ? PH_CALIB : r_phase;
    assign e_cnt   = r3_ts ? '0 : r_cnt;
    assign e_q     = r3_ts ? '0 : r_q;
    assign e_rem   = r3_ts ? '0 : r_rem;

    // Running average: the sum is kept as quotient and remainder by CAL_GROUPS.
    assign c_rsum  = {1'b0, e_rem} + {1'b0, r3_rem};
    assign c_carry = 32'(c_rsum) >= 32'(CAL_GROUPS);

    // Threshold compares, done without dividing: avg*pct/100 against the latency.
    assign c_q_long     = PROD_W'(r_q) * PROD_W'(LONG_PCT);
    assign c_q_short    = PROD_W'(r_q) * PROD_W'(SHORT_PCT);
    assign c_q_normal   = PROD_W'(r_q) * PROD_W'(NORMAL_PCT);
    assign c_lat_up     = r3_lat100 + PROD_W'(PCT_BASE - 1);
    assign c_hit_long   = c_q_long <= c_lat_up;
    assign c_hit_short  = r3_lat100 <= c_q_short;
    assign c_hit_normal = c_q_normal <= c_lat_up;

    // Offset checks once the normal region is found.
    assign c_diff = r3_ofs - r_long;
    assign c_len  = c_diff >> 1;
    assign c_rnd  = (r_long + t_ofs'(RND_HALF)) & ~t_ofs'(RND_MASK);
    assign c_dofs = c_rnd - t_ofs'(DATA_BACK);

    always_comb begin
        if (r_short < r_long || r3_ofs < r_short) begin
            c_fin_status = ST_ORDER;
        end else if (32'(r_long) < 32'(WIN_LO) || 32'(r_long) > 32'(WIN_HI)) begin
            c_fin_status = ST_WINDOW;
        end else if (32'(c_len) < 32'(LEN_MIN) || 32'(c_len) > 32'(LEN_MAX)) begin
            c_fin_status = ST_LENGTH;
        end else begin
            c_fin_status = ST_FOUND;
        end
    end

    // Next state of the detector.
    always_comb begin
        n_phase = e_phase;
        n_cnt   = e_cnt;
        n_q     = e_q;
        n_rem   = e_rem;
        n_long  = r_long;
        n_short = r_short;
        case (e_phase)
            PH_CALIB: begin
                if (r3_se) begin
                    n_phase = PH_DONE;
                end else begin
                    n_cnt = e_cnt + CNT_W'(1);
                    n_q   = e_q + LAT_W'(r3_quo) + LAT_W'(c_carry);
                    n_rem = c_carry ? REM_W'(c_rsum - (REM_W+1)'(CAL_GROUPS)) : REM_W'(c_rsum);
                    if (32'(n_cnt) >= 32'(CAL_GROUPS)) begin
                        n_phase = PH_LONG;
                    end
                end
            end
            PH_LONG: begin
                if (r3_se) begin
                    n_phase = PH_DONE;
                end else if (c_hit_long) begin
                    n_long  = r3_ofs;
                    n_phase = PH_SHORT;
                end
            end
            PH_SHORT: begin
                if (r3_se) begin
                    n_phase = PH_DONE;
                end else if (c_hit_short) begin
                    n_short = r3_ofs;
                    n_phase = PH_NORMAL;
                end
            end
            PH_NORMAL: begin
                if (r3_se || c_hit_normal) begin
                    n_phase = PH_DONE;
                end
            end
            default: begin
                n_phase = e_phase;
            end
        endcase
    end

    // Status word produced by the word in the detection stage.
    always_comb begin
        c_emit   = 1'b0;
        c_status = ST_STREAM;
        c_data   = '0;
        case (e_phase)
            PH_CALIB, PH_LONG, PH_SHORT: begin
                c_emit = r3_se;
            end
            PH_NORMAL: begin
                if (r3_se) begin
                    c_emit = 1'b1;
                end else if (c_hit_normal) begin
                    c_emit   = 1'b1;
                    c_status = c_fin_status;
                    if (c_fin_status == ST_FOUND) begin
                        c_data = DBO_W'(c_dofs);
                    end
                end
            end
            default: begin
                c_emit = 1'b0;
            end
        endcase
    end

    // Detector state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CALIB;
            r_cnt   <= '0;
            r_q     <= '0;
            r_rem   <= '0;
        end else if (c_take3) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_q     <= n_q;
            r_rem   <= n_rem;
        end
        if (c_take3) begin
            r_long  <= n_long;
            r_short <= n_short;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (c_take3 && c_emit) begin
            r_ov <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ov <= 1'b0;
        end
        if (c_take3 && c_emit) begin
            r_out_status <= c_status;
            r_out_data   <= c_data;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = OUT_DATA_W'(r_out_data);

    // Assertions.
    `VDTD_ASSERT_NXT(a_done_after_status, i_clk, i_rst_n, c_take3 && c_emit, r_phase == PH_DONE, "status word sent but search not closed")
    `VDTD_ASSERT_IMP(a_rem_range, i_clk, i_rst_n, 1'b1, 32'(r_rem) < 32'(CAL_GROUPS), "running remainder out of range")
    `VDTD_ASSERT_IMP(a_count_in_search, i_clk, i_rst_n, r_phase == PH_LONG || r_phase == PH_SHORT || r_phase == PH_NORMAL, 32'(r_cnt) == 32'(CAL_GROUPS), "search started before calibration completed")
    `VDTD_ASSERT_IMP(a_zero_data_on_fail, i_clk, i_rst_n, r_ov && r_out_status != ST_FOUND, r_out_data == '0, "data offset set on a failure status")

endmodule

// ----- verif/track_status_checker.sv -----
// Checker for the variable density track detector: watches both stream channels,
// predicts the status word of each track and compares it with what the block sends.
// Depends on vdtd_pkg for widths, phase and status codes.
`timescale 1ns / 1ps

module track_status_checker
    import vdtd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,    // group_latency, bit_offset
    input  logic                  i_s_tuser,    // track_start
    input  logic                  i_s_tlast,    // stream_end
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,    // data_bit_offset
    input  logic [STATUS_W-1:0]   i_m_tuser,    // status
    output int                    o_mismatches,
    output int                    o_outstanding,
    output int                    o_predicted
);

    typedef struct packed {
        t_status status;
        t_ofs    data_ofs;
    } status_word_t;

    // Our own copy of the detection state.
    t_phase       trk_phase;
    logic [10:0]  cal_count;
    logic [34:0]  cal_sum;
    logic [25:0]  long_lim;
    logic [25:0]  short_lim;
    logic [25:0]  normal_lim;
    t_ofs         long_pos;
    t_ofs         short_pos;
    status_word_t pending_status_q[$];

    task automatic clear_track();
        trk_phase  = PH_CALIB;
        cal_count  = '0;
        cal_sum    = '0;
        long_lim   = '0;
        short_lim  = '0;
        normal_lim = '0;
        long_pos   = '0;
        short_pos  = '0;
    endtask

    // Every status word ends the track until the next track start.
    task automatic post_status(input t_status st, input t_ofs data_ofs);
        status_word_t w;
        w.status   = st;
        w.data_ofs = data_ofs;
        pending_status_q.push_back(w);
        o_predicted = o_predicted + 1;
        trk_phase   = PH_DONE;
    endtask

    // Advances the detection state by one accepted group word.
    task automatic predict_track_status(input logic ts, input logic [LAT_W-1:0] lat,
                                        input t_ofs ofs, input logic se);
        longint unsigned mean;
        t_ofs            half_span;
        int              rounded;
        if (ts)
            clear_track();
        if (trk_phase != PH_DONE) begin
            if (se) begin
                post_status(ST_STREAM, '0);
            end else begin
                case (trk_phase)
                    PH_CALIB: begin
                        cal_sum   = cal_sum + lat;
                        cal_count = cal_count + 1'b1;
                        if (cal_count >= CAL_GROUPS) begin
                            mean       = cal_sum / CAL_GROUPS;
                            long_lim   = (mean * LONG_PCT) / PCT_BASE;
                            short_lim  = (mean * SHORT_PCT) / PCT_BASE;
                            normal_lim = (mean * NORMAL_PCT) / PCT_BASE;
                            trk_phase  = PH_LONG;
                        end
                    end
                    PH_LONG: begin
                        if (lat >= long_lim) begin
                            long_pos  = ofs;
                            trk_phase = PH_SHORT;
                        end
                    end
                    PH_SHORT: begin
                        if (lat <= short_lim) begin
                            short_pos = ofs;
                            trk_phase = PH_NORMAL;
                        end
                    end
                    default: begin
                        // Normal length found: grade the three offsets.
                        if (lat >= normal_lim) begin
                            if (short_pos < long_pos || ofs < short_pos) begin
                                post_status(ST_ORDER, '0);
                            end else if (long_pos < WIN_LO || long_pos > WIN_HI) begin
                                post_status(ST_WINDOW, '0);
                            end else begin
                                half_span = (ofs - long_pos) >> 1;
                                if (half_span < LEN_MIN || half_span > LEN_MAX) begin
                                    post_status(ST_LENGTH, '0);
                                end else begin
                                    rounded = ((int'(long_pos) + RND_HALF) & ~RND_MASK)
                                              - DATA_BACK;
                                    post_status(ST_FOUND, rounded[OFS_W-1:0]);
                                end
                            end
                        end
                    end
                endcase
            end
        end
    endtask

    // Input words are predicted before output words are checked in the same cycle.
    always @(posedge i_clk) begin : watch
        status_word_t exp_w;
        if (!i_rst_n) begin
            clear_track();
            pending_status_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                predict_track_status(i_s_tuser, i_s_tdata[LAT_W-1:0],
                                     i_s_tdata[LAT_W +: BOF_W], i_s_tlast);
            if (i_m_tvalid && i_m_tready) begin
                if (pending_status_q.size() == 0) begin
                    o_mismatches = o_mismatches + 1;
                    if (o_mismatches <= 10)
                        $display("%0t: status word with none expected: status %0d offset %0d",
                                 $time, i_m_tuser, i_m_tdata[DBO_W-1:0]);
                end else begin
                    exp_w = pending_status_q.pop_front();
                    if (i_m_tuser !== exp_w.status ||
                        i_m_tdata[DBO_W-1:0] !== exp_w.data_ofs) begin
                        o_mismatches = o_mismatches + 1;
                        if (o_mismatches <= 10)
                            $display("%0t: status word: expected status %0d offset %0d, got status %0d offset %0d",
                                     $time, exp_w.status, exp_w.data_ofs,
                                     i_m_tuser, i_m_tdata[DBO_W-1:0]);
                    end
                end
            end
        end
        o_outstanding = pending_status_q.size();
    end

endmodule

// ----- verif/tb_variable_density_track_detector_unit.sv -----
// Top of the track detector testbench: clock, reset, track stimulus and the verdict.
// Depends on vdtd_pkg, variable_density_track_detector_unit and track_status_checker.
`timescale 1ns / 1ps

module tb_variable_density_track_detector_unit;
    import vdtd_pkg::*;

    localparam int     LAT_MAX      = (1 << LAT_W) - 1;
    localparam int     OFS_MAX      = (1 << OFS_W) - 1;
    localparam int     ITEM_GOAL    = 1600;
    localparam int     RESULT_GOAL  = 40;
    localparam int     DRAIN_CYCLES = 40;
    localparam longint TIMEOUT_NS   = 10_000_000;

    typedef enum int {
        TRK_FOUND,
        TRK_ORDER,
        TRK_WINDOW,
        TRK_LENGTH,
        TRK_END_CAL,
        TRK_END_SEARCH,
        TRK_ABANDON,
        TRK_START_END
    } track_kind_t;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;   // group_latency, bit_offset
    logic                  s_tuser  = 1'b0; // track_start
    logic                  s_tlast  = 1'b0; // stream_end
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_tdata;         // data_bit_offset
    logic [STATUS_W-1:0]   m_tuser;         // status

    int mismatches;
    int outstanding;
    int predicted;
    int sent_items = 0;
    int tx_mode    = 0;
    int rx_mode    = 0;
    int rx_hold    = 0;
    bit calm       = 1'b0;

    always #5 clk = ~clk;

    variable_density_track_detector_unit i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    track_status_checker u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_s_tlast     (s_tlast),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_predicted   (predicted)
    );

    // Receiver back-pressure in random bursts.
    always @(negedge clk) begin
        if (rx_hold > 0)
            rx_hold = rx_hold - 1;
        else if (!calm && rx_mode != 0 && $urandom_range(0, (rx_mode == 1) ? 15 : 3) == 0)
            rx_hold = $urandom_range(1, 4);
        m_tready <= (rx_hold == 0);
    end

    // Offers one word from a falling edge and returns at the falling edge after it is taken.
    task automatic send_word(input logic ts, input logic [LAT_W-1:0] lat, input t_ofs ofs,
                             input logic se, input bit counted);
        logic [IN_DATA_W-1:0] word;
        if (!calm && tx_mode != 0 && $urandom_range(0, (tx_mode == 1) ? 15 : 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        word                   = '0;
        word[LAT_W-1:0]        = lat;
        word[LAT_W +: BOF_W]   = ofs;
        s_tdata  <= word;
        s_tuser  <= ts;
        s_tlast  <= se;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        if (counted)
            sent_items = sent_items + 1;
    endtask

    // A few words after the status word; the block should ignore them.
    task automatic send_tail();
        repeat ($urandom_range(0, 3))
            send_word(1'b0, $urandom_range(0, LAT_MAX), $urandom_range(0, OFS_MAX),
                      $urandom_range(0, 1), 1'b0);
    endtask

    // Groups that are neither long, short nor back at normal length.
    task automatic send_fillers(input longint unsigned lo_cut, input longint unsigned ok_cut);
        int n;
        n = (ok_cut > lo_cut + 1) ? $urandom_range(0, 6) : 0;
        repeat (n)
            send_word(1'b0, $urandom_range(lo_cut + 1, ok_cut - 1), $urandom_range(0, OFS_MAX),
                      1'b0, 1'b1);
    endtask

    // A latency that meets a lower threshold, often right on it.
    function automatic logic [LAT_W-1:0] at_or_above(input longint unsigned cut);
        longint unsigned v;
        case ($urandom_range(0, 3))
            0:       v = cut;
            1:       v = cut + 1;
            2:       v = $urandom_range(cut, LAT_MAX);
            default: v = LAT_MAX;
        endcase
        if (v > LAT_MAX)
            v = LAT_MAX;
        return v[LAT_W-1:0];
    endfunction

    // One track: calibration, then the long, short and normal searches, cut short by kind.
    task automatic run_track(input track_kind_t kind);
        longint unsigned  base;
        longint unsigned  spread;
        longint unsigned  cal_total;
        longint unsigned  mean;
        longint unsigned  hi_cut;
        longint unsigned  lo_cut;
        longint unsigned  ok_cut;
        logic [LAT_W-1:0] lat;
        int               n_cal;
        int               quit_at;
        int               long_at;
        int               short_at;
        int               norm_at;
        int               dist2;
        bit               stopped;
        tx_mode = $urandom_range(0, 2);
        rx_mode = $urandom_range(0, 2);
        if (kind == TRK_START_END) begin
            send_word(1'b1, $urandom_range(0, LAT_MAX), $urandom_range(0, OFS_MAX), 1'b1, 1'b1);
            send_tail();
        end else begin
            case ($urandom_range(0, 5))
                0:       base = $urandom_range(0, 200);
                1:       base = $urandom_range(15_000_000, 15_300_000);
                default: base = $urandom_range(2000, 15_000_000);
            endcase
            spread = base / 100;
            case (kind)
                TRK_END_CAL: n_cal = ($urandom_range(0, 7) == 0) ? CAL_GROUPS - 1
                                                                 : $urandom_range(1, 40);
                TRK_ABANDON: n_cal = ($urandom_range(0, 2) == 0) ? CAL_GROUPS
                                                                 : $urandom_range(1, 60);
                default:     n_cal = CAL_GROUPS;
            endcase

            // Calibration groups jitter by up to one percent around the base latency.
            cal_total = 0;
            for (int i = 0; i < n_cal; i++) begin
                lat = base - spread + $urandom_range(0, 2 * spread);
                send_word(i == 0, lat, $urandom_range(0, OFS_MAX), 1'b0, 1'b1);
                cal_total = cal_total + lat;
            end

            if (kind == TRK_END_CAL) begin
                send_word(1'b0, $urandom_range(0, LAT_MAX), $urandom_range(0, OFS_MAX),
                          1'b1, 1'b1);
                send_tail();
            end else if (!(kind == TRK_ABANDON && n_cal < CAL_GROUPS)) begin
                mean   = cal_total / CAL_GROUPS;
                hi_cut = (mean * LONG_PCT) / PCT_BASE;
                lo_cut = (mean * SHORT_PCT) / PCT_BASE;
                ok_cut = (mean * NORMAL_PCT) / PCT_BASE;

                // Region offsets chosen to land on the intended outcome.
                case (kind)
                    TRK_WINDOW: begin
                        case ($urandom_range(0, 3))
                            0:       long_at = WIN_LO - 1;
                            1:       long_at = WIN_HI + 1;
                            2:       long_at = $urandom_range(0, WIN_LO - 1);
                            default: long_at = $urandom_range(WIN_HI + 1, 240000);
                        endcase
                        norm_at  = long_at + $urandom_range(0, 20000);
                        short_at = $urandom_range(long_at, norm_at);
                    end
                    TRK_ORDER: begin
                        if ($urandom_range(0, 1)) begin
                            long_at  = $urandom_range(1, OFS_MAX);
                            short_at = $urandom_range(0, long_at - 1);
                            norm_at  = $urandom_range(0, OFS_MAX);
                        end else begin
                            long_at  = $urandom_range(0, OFS_MAX - 1);
                            short_at = $urandom_range(long_at + 1, OFS_MAX);
                            norm_at  = $urandom_range(0, short_at - 1);
                        end
                    end
                    default: begin
                        case ($urandom_range(0, 3))
                            0:       long_at = WIN_LO;
                            1:       long_at = WIN_HI;
                            default: long_at = $urandom_range(WIN_LO, WIN_HI);
                        endcase
                        if (kind == TRK_LENGTH) begin
                            case ($urandom_range(0, 3))
                                0:       dist2 = 2 * LEN_MIN - 1;
                                1:       dist2 = 2 * LEN_MAX + 2;
                                2:       dist2 = $urandom_range(0, 2 * LEN_MIN - 1);
                                default: dist2 = $urandom_range(2 * LEN_MAX + 2, 20000);
                            endcase
                        end else begin
                            case ($urandom_range(0, 3))
                                0:       dist2 = 2 * LEN_MIN;
                                1:       dist2 = 2 * LEN_MAX + 1;
                                default: dist2 = $urandom_range(2 * LEN_MIN, 2 * LEN_MAX + 1);
                            endcase
                        end
                        norm_at = long_at + dist2;
                        case ($urandom_range(0, 3))
                            0:       short_at = long_at;
                            1:       short_at = norm_at;
                            default: short_at = $urandom_range(long_at, norm_at);
                        endcase
                    end
                endcase

                quit_at = (kind == TRK_END_SEARCH || kind == TRK_ABANDON)
                          ? $urandom_range(1, 3) : 0;
                stopped = 1'b0;

                // Stage 1 seeks the long region, 2 the short one, 3 the return to normal.
                for (int stage = 1; stage <= 3 && !stopped; stage++) begin
                    send_fillers(lo_cut, ok_cut);
                    case (stage)
                        1: if (hi_cut > 0 && $urandom_range(0, 1))
                               send_word(1'b0, hi_cut - 1, $urandom_range(0, OFS_MAX),
                                         1'b0, 1'b1);
                        2: if (lo_cut < LAT_MAX && $urandom_range(0, 1))
                               send_word(1'b0, lo_cut + 1, $urandom_range(0, OFS_MAX),
                                         1'b0, 1'b1);
                        default: if (ok_cut > 0 && $urandom_range(0, 1))
                               send_word(1'b0, ok_cut - 1, $urandom_range(0, OFS_MAX),
                                         1'b0, 1'b1);
                    endcase
                    if (quit_at == stage) begin
                        // Abandoned tracks simply run into the next track start.
                        if (kind == TRK_END_SEARCH) begin
                            send_word(1'b0, $urandom_range(0, LAT_MAX),
                                      $urandom_range(0, OFS_MAX), 1'b1, 1'b1);
                            send_tail();
                        end
                        stopped = 1'b1;
                    end else begin
                        case (stage)
                            1: send_word(1'b0, at_or_above(hi_cut), long_at, 1'b0, 1'b1);
                            2: begin
                                case ($urandom_range(0, 3))
                                    0:       lat = lo_cut;
                                    1:       lat = (lo_cut > 0) ? lo_cut - 1 : 0;
                                    2:       lat = $urandom_range(0, lo_cut);
                                    default: lat = '0;
                                endcase
                                send_word(1'b0, lat, short_at, 1'b0, 1'b1);
                            end
                            default: begin
                                send_word(1'b0, at_or_above(ok_cut), norm_at, 1'b0, 1'b1);
                                send_tail();
                            end
                        endcase
                    end
                end
            end
        end
    endtask

    initial begin : stimulus
        track_kind_t kind;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, stream end in calibration, words after done,
        // track start together with stream end, and a restart mid-calibration.
        send_word(1'b0, '0, '0, 1'b0, 1'b1);
        send_word(1'b0, LAT_MAX, OFS_MAX, 1'b0, 1'b1);
        send_word(1'b0, LAT_MAX, OFS_MAX, 1'b1, 1'b1);
        send_word(1'b0, $urandom_range(0, LAT_MAX), $urandom_range(0, OFS_MAX), 1'b0, 1'b0);
        send_word(1'b0, $urandom_range(0, LAT_MAX), $urandom_range(0, OFS_MAX), 1'b1, 1'b0);
        send_word(1'b1, '0, '0, 1'b1, 1'b1);
        send_word(1'b1, '0, OFS_MAX, 1'b1, 1'b1);
        send_word(1'b1, LAT_MAX, '0, 1'b0, 1'b1);
        send_word(1'b0, 1, 1, 1'b0, 1'b1);
        send_word(1'b1, LAT_MAX, OFS_MAX, 1'b0, 1'b1);
        send_word(1'b0, '0, '0, 1'b1, 1'b1);

        // Every track outcome once, then a random mix.
        for (int k = 0; k <= TRK_START_END; k++)
            run_track(track_kind_t'(k));
        while (predicted < RESULT_GOAL || sent_items < ITEM_GOAL) begin
            if (predicted >= RESULT_GOAL - 6 && sent_items >= ITEM_GOAL)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0, 1:    kind = TRK_FOUND;
                2:       kind = TRK_ORDER;
                3:       kind = TRK_WINDOW;
                4:       kind = TRK_LENGTH;
                5:       kind = TRK_END_SEARCH;
                7:       kind = TRK_ABANDON;
                8:       kind = TRK_START_END;
                default: kind = TRK_END_CAL;
            endcase
            run_track(kind);
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding status words, then give the pipeline time to misbehave.
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
